>>> rtl/core/bkm_pkg.sv
// shared types, register codes and sine table helper for the binary keying modulator
`default_nettype none
package bkm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int AMP_W      = 12;
	localparam int REG_W      = 16;
	localparam int SPB_W      = 7;
	localparam int CNT_W      = 7;
	localparam int ROM_W      = 16;
	localparam int SAMPLE_W   = 13;
	localparam int OUT_LIMIT  = 64;

	// reset values of the configuration registers
	localparam logic [AMP_W-1:0] AMP_ZERO_RST    = 12'd0;
	localparam logic [AMP_W-1:0] AMP_ONE_RST     = 12'd2048;
	localparam logic [REG_W-1:0] STEP_ZERO_RST   = 16'd6554;
	localparam logic [REG_W-1:0] STEP_ONE_RST    = 16'd6554;
	localparam logic [REG_W-1:0] OFFSET_ZERO_RST = 16'd0;
	localparam logic [REG_W-1:0] OFFSET_ONE_RST  = 16'd0;
	localparam logic [SPB_W-1:0] SPB_RST         = 7'd10;
	localparam logic [REG_W-1:0] BIT_LIMIT_RST   = 16'd0;

	// pi/2 in Q28
	localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_ZERO    = 3'd0,
		REG_AMP_ONE     = 3'd1,
		REG_STEP_ZERO   = 3'd2,
		REG_STEP_ONE    = 3'd3,
		REG_OFFSET_ZERO = 3'd4,
		REG_OFFSET_ONE  = 3'd5,
		REG_SPB         = 3'd6,
		REG_BIT_LIMIT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [AMP_W-1:0] amp_zero;
		logic [AMP_W-1:0] amp_one;
		logic [REG_W-1:0] step_zero;
		logic [REG_W-1:0] step_one;
		logic [REG_W-1:0] offset_zero;
		logic [REG_W-1:0] offset_one;
		logic [SPB_W-1:0] spb;
		logic [REG_W-1:0] bit_limit;
	} cfg_t;

	typedef struct packed {
		logic             issue;
		logic [REG_W-1:0] bits_sent;
	} gen_status_t;

	// sine of (pi/2)*r/2^qshift as unsigned Q0.15, Q28 taylor series, elaboration time only
	function automatic logic [14:0] quarter_sine(input int unsigned qshift,
			input int unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned v;
		longint          s;
		x  = (HALF_PI_Q28 * 64'(r)) >> qshift;
		x2 = (x * x) >> 28;
		t  = x;
		s  = longint'(x);
		t = ((t * x2) >> 28) / 64'd6;   s = s - longint'(t);
		t = ((t * x2) >> 28) / 64'd20;  s = s + longint'(t);
		t = ((t * x2) >> 28) / 64'd42;  s = s - longint'(t);
		t = ((t * x2) >> 28) / 64'd72;  s = s + longint'(t);
		t = ((t * x2) >> 28) / 64'd110; s = s - longint'(t);
		t = ((t * x2) >> 28) / 64'd156; s = s + longint'(t);
		t = ((t * x2) >> 28) / 64'd210; s = s - longint'(t);
		t = ((t * x2) >> 28) / 64'd272; s = s + longint'(t);
		if (s < 0) begin
			s = 0;
		end
		v = (unsigned'(s) * 64'd32767 + (64'd1 << 27)) >> 28;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/bkm_regs.sv
// configuration register file of the binary keying modulator
`default_nettype none
module bkm_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [bkm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bkm_pkg::CFG_DATA_W-1:0] wr_data,
	output bkm_pkg::cfg_t                       cfg
);

	bkm_pkg::cfg_t cfg_q;

	assign cfg = cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amp_zero    <= bkm_pkg::AMP_ZERO_RST;
			cfg_q.amp_one     <= bkm_pkg::AMP_ONE_RST;
			cfg_q.step_zero   <= bkm_pkg::STEP_ZERO_RST;
			cfg_q.step_one    <= bkm_pkg::STEP_ONE_RST;
			cfg_q.offset_zero <= bkm_pkg::OFFSET_ZERO_RST;
			cfg_q.offset_one  <= bkm_pkg::OFFSET_ONE_RST;
			cfg_q.spb         <= bkm_pkg::SPB_RST;
			cfg_q.bit_limit   <= bkm_pkg::BIT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (bkm_pkg::reg_idx_t'(wr_index))
				bkm_pkg::REG_AMP_ZERO:    cfg_q.amp_zero    <= wr_data[bkm_pkg::AMP_W-1:0];
				bkm_pkg::REG_AMP_ONE:     cfg_q.amp_one     <= wr_data[bkm_pkg::AMP_W-1:0];
				bkm_pkg::REG_STEP_ZERO:   cfg_q.step_zero   <= wr_data;
				bkm_pkg::REG_STEP_ONE:    cfg_q.step_one    <= wr_data;
				bkm_pkg::REG_OFFSET_ZERO: cfg_q.offset_zero <= wr_data;
				bkm_pkg::REG_OFFSET_ONE:  cfg_q.offset_one  <= wr_data;
				bkm_pkg::REG_SPB:         cfg_q.spb         <= wr_data[bkm_pkg::SPB_W-1:0];
				bkm_pkg::REG_BIT_LIMIT:   cfg_q.bit_limit   <= wr_data;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/bkm_sine_rom.sv
// full-cycle sine rom with registered read
`default_nettype none
module bkm_sine_rom #(
	parameter int SINE_ADDR_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             rd_en,
	input  wire logic [SINE_ADDR_BITS-1:0]        rd_addr,
	output logic signed [bkm_pkg::ROM_W-1:0]      rd_data
);

	localparam int ROM_SIZE      = 2 ** SINE_ADDR_BITS;
	localparam int QUARTER_SHIFT = SINE_ADDR_BITS - 2;

	typedef logic signed [bkm_pkg::ROM_W-1:0] rom_arr_t [ROM_SIZE];

	// quarter wave mirrored into all four quadrants
	function automatic rom_arr_t build_rom();
		rom_arr_t    rom;
		int unsigned quarter;
		int unsigned q;
		int unsigned r;
		logic [14:0] s;
		quarter = 1 << QUARTER_SHIFT;
		for (int k = 0; k < ROM_SIZE; k++) begin
			q = unsigned'(k) >> QUARTER_SHIFT;
			r = unsigned'(k) & (quarter - 1);
			s = q[0] ? bkm_pkg::quarter_sine(QUARTER_SHIFT, quarter - r)
			         : bkm_pkg::quarter_sine(QUARTER_SHIFT, r);
			rom[k] = q[1] ? -signed'({1'b0, s}) : signed'({1'b0, s});
		end
		return rom;
	endfunction

	localparam rom_arr_t ROM = build_rom();

	logic signed [bkm_pkg::ROM_W-1:0] data_q;

	assign rd_data = data_q;

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= ROM[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/bkm_gen.sv
// bit sequencer: limit check, bit count and per-sample phase accumulator
`default_nettype none
module bkm_gen #(
	parameter int PHASE_BITS     = 16,
	parameter int SINE_ADDR_BITS = 10,
	parameter int MAX_SAMPLES    = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bkm_pkg::cfg_t               cfg,
	input  wire logic                        adv,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        data_bit,
	input  wire logic                        message_start,
	output logic [SINE_ADDR_BITS-1:0]        rom_addr,
	output logic [bkm_pkg::AMP_W-1:0]        amp,
	output logic                             last,
	output bkm_pkg::gen_status_t             status
);

	localparam int CNT_W = bkm_pkg::CNT_W;
	localparam int REG_W = bkm_pkg::REG_W;
	localparam int CAP   = (MAX_SAMPLES < bkm_pkg::OUT_LIMIT) ? MAX_SAMPLES
	                                                           : bkm_pkg::OUT_LIMIT;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
	localparam logic [REG_W-1:0] CNT_MAX = '1;

	logic                     busy_q;
	logic [CNT_W-1:0]         remain_q;
	logic [REG_W-1:0]         bits_sent_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [PHASE_BITS-1:0]    step_q;
	logic [bkm_pkg::AMP_W-1:0] amp_q;

	logic                     take;
	logic                     issue;
	logic                     limited;
	logic                     start;
	logic [REG_W-1:0]         base;
	logic [CNT_W-1:0]         count;
	logic [REG_W-1:0]         sel_step;
	logic [REG_W-1:0]         sel_offset;
	logic [PHASE_BITS-1:0]    step_al;
	logic [PHASE_BITS-1:0]    offset_al;

	// next item enters as the last sample of the current one leaves
	assign in_ready = adv && (!busy_q || remain_q == ONE_C);
	assign take     = in_valid && in_ready;
	assign issue    = busy_q && adv;

	// limit check on the count after an optional message restart
	assign base    = message_start ? '0 : bits_sent_q;
	assign limited = (cfg.bit_limit != '0) && (base >= cfg.bit_limit);
	assign count   = (cfg.spb > CAP_C) ? CAP_C : cfg.spb;
	assign start   = take && !limited && (count != '0);

	assign sel_step   = data_bit ? cfg.step_one : cfg.step_zero;
	assign sel_offset = data_bit ? cfg.offset_one : cfg.offset_zero;

	// align 16-bit phase registers to the phase word
	if (PHASE_BITS == REG_W) begin : g_ph_eq
		assign step_al   = sel_step;
		assign offset_al = sel_offset;
	end else if (PHASE_BITS > REG_W) begin : g_ph_up
		assign step_al   = {sel_step, {(PHASE_BITS-REG_W){1'b0}}};
		assign offset_al = {sel_offset, {(PHASE_BITS-REG_W){1'b0}}};
	end else begin : g_ph_dn
		assign step_al   = sel_step[REG_W-1 -: PHASE_BITS];
		assign offset_al = sel_offset[REG_W-1 -: PHASE_BITS];
	end

	// rom address from the top of the phase word
	if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_ad_dn
		assign rom_addr = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
	end else begin : g_ad_up
		assign rom_addr = {phase_q, {(SINE_ADDR_BITS-PHASE_BITS){1'b0}}};
	end

	assign amp  = amp_q;
	assign last = (remain_q == ONE_C);

	assign status.issue     = issue;
	assign status.bits_sent = bits_sent_q;

	// sample countdown and bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			remain_q    <= '0;
			bits_sent_q <= '0;
		end else begin
			if (start) begin
				busy_q   <= 1'b1;
				remain_q <= count;
			end else if (issue) begin
				remain_q <= remain_q - ONE_C;
				if (remain_q == ONE_C) begin
					busy_q <= 1'b0;
				end
			end
			if (take) begin
				if (limited || base == CNT_MAX) begin
					bits_sent_q <= base;
				end else begin
					bits_sent_q <= base + REG_W'(1);
				end
			end
		end
	end

	// phase accumulator and per-bit settings
	always_ff @(posedge clk) begin
		if (start) begin
			phase_q <= offset_al;
			step_q  <= step_al;
			amp_q   <= data_bit ? cfg.amp_one : cfg.amp_zero;
		end else if (issue) begin
			phase_q <= phase_q + step_q;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/bkm_scale.sv
// amplitude scaling with rounding and the output register
`default_nettype none
module bkm_scale (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire logic                            issue,
	input  wire logic [bkm_pkg::AMP_W-1:0]       amp,
	input  wire logic                            last,
	input  wire logic signed [bkm_pkg::ROM_W-1:0] rom_data,
	output logic                                 out_valid,
	output logic signed [bkm_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                 out_last
);

	localparam int AMP_W  = bkm_pkg::AMP_W;
	localparam int MAG_W  = bkm_pkg::ROM_W - 1;
	localparam int PROD_W = AMP_W + MAG_W;

	logic                    valid_s1;
	logic [AMP_W-1:0]        amp_s1;
	logic                    last_s1;
	logic                    valid_q;
	logic signed [bkm_pkg::SAMPLE_W-1:0] sample_q;
	logic                    last_q;

	logic                    neg;
	logic [bkm_pkg::ROM_W-1:0] abs_full;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [PROD_W-1:0]       rounded;
	logic [AMP_W-1:0]        scaled;
	logic [bkm_pkg::SAMPLE_W-1:0] val;

	// magnitude times amplitude, rounded half away from zero
	assign neg      = rom_data[bkm_pkg::ROM_W-1];
	assign abs_full = neg ? unsigned'(-rom_data) : unsigned'(rom_data);
	assign mag      = abs_full[MAG_W-1:0];
	assign prod     = PROD_W'(amp_s1) * PROD_W'(mag);
	assign rounded  = prod + PROD_W'(16384);
	assign scaled   = rounded[PROD_W-1 -: AMP_W];
	assign val      = neg ? -{1'b0, scaled} : {1'b0, scaled};

	assign out_valid  = valid_q;
	assign out_sample = sample_q;
	assign out_last   = last_q;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_q  <= valid_s1;
		end
	end

	// payload alongside the rom read and the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			amp_s1   <= amp;
			last_s1  <= last;
			sample_q <= signed'(val);
			last_q   <= last_s1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/binary_keying_modulator_top.sv
// Binary keying modulator: each input bit becomes a burst of scaled sine samples.
// Input stream s_*: one item per bit, tdata[0] the data bit, tdata[1] message start.
// Output stream m_*: one item per sample, tdata[12:0] the signed sample (value/1024),
// tlast set on the final sample of a bit.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready; write
// only while no bit is in flight. Amplitude, phase step and start phase per bit value
// select ASK, PSK or FSK.
// The first sample of a bit passes the phase register, the registered rom read and the
// scaled output register before it is presented on m_*.
// Each bit gives samples_per_bit samples (capped at 64 and MAX_SAMPLES), one sample per
// cycle while the output does not stall, from the single phase accumulator and its rom
// read port. A bit that hits the bit limit or has zero samples gives no sample.
// Reset clears configuration to defaults, the bit count and all pipeline valids.
// When m_tvalid is high and m_tready is low the whole pipeline holds and no new bit is taken.
`default_nettype none
module binary_keying_modulator_top #(
	parameter int PHASE_BITS     = 16,
	parameter int SINE_ADDR_BITS = 10,
	parameter int MAX_SAMPLES    = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // data_bit, message_start
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [15:0]                         m_tdata,  // sample
	output logic                                m_tlast,  // last_of_bit
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bkm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bkm_pkg::CFG_DATA_W-1:0] cfg_data
);

	bkm_pkg::cfg_t         cfg;
	bkm_pkg::gen_status_t  gen_st;
	logic                  adv;
	logic [SINE_ADDR_BITS-1:0] rom_addr;
	logic [bkm_pkg::AMP_W-1:0] amp;
	logic                  last;
	logic signed [bkm_pkg::ROM_W-1:0] rom_data;
	logic signed [bkm_pkg::SAMPLE_W-1:0] sample;

	// pipeline moves whenever the output register is free or being taken
	assign adv       = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {{(16-bkm_pkg::SAMPLE_W){1'b0}}, sample};

	bkm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bkm_gen #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.MAX_SAMPLES    (MAX_SAMPLES)
	) u_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.adv           (adv),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.data_bit      (s_tdata[0]),
		.message_start (s_tdata[1]),
		.rom_addr      (rom_addr),
		.amp           (amp),
		.last          (last),
		.status        (gen_st)
	);

	bkm_sine_rom #(
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_rom (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	bkm_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.issue      (gen_st.issue),
		.amp        (amp),
		.last       (last),
		.rom_data   (rom_data),
		.out_valid  (m_tvalid),
		.out_sample (sample),
		.out_last   (m_tlast)
	);

`ifndef SYNTH
	// no new bit is taken while the output is stalled
	a_ready_needs_adv: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> adv)
		else $error("input taken while pipeline stalled");

	// no sample is issued into a stalled pipeline
	a_no_issue_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !gen_st.issue)
		else $error("sample issued while output stalled");

	// the bit count holds, steps by one, or restarts
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (gen_st.bits_sent == $past(gen_st.bits_sent))
			|| (gen_st.bits_sent == $past(gen_st.bits_sent) + 16'd1)
			|| (gen_st.bits_sent == 16'd0)
			|| (gen_st.bits_sent == 16'd1))
		else $error("bit count jumped");
`endif

endmodule
`default_nettype wire

>>> bench/tb_binary_keying_modulator_top.sv
// self-checking testbench for the binary keying modulator: directed table and random phases
`timescale 1ns / 100ps
module tb_binary_keying_modulator_top;

	localparam int  SAMPLE_CAP  = 64;
	localparam int  CYCLE_LIMIT = 1500000;
	localparam int  PLAN_LEN    = 41;
	localparam int  SETTLE_GAP  = 8;
	localparam int  ITEM_TARGET = 100;

	typedef enum logic {ROW_BIT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		bkm_pkg::reg_idx_t idx;
		logic [15:0] value;
		logic      data_bit;
		logic      msg_start;
		bit        typed;
		int        n_typed;
		int        typed_val;
	} plan_row_t;

	typedef struct {
		logic signed [12:0] sample;
		logic               last;
	} sample_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [bkm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bkm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the registers and the bit count
	bkm_pkg::cfg_t keying;
	logic [15:0] bits_sent;
	int          sine_table [1024];

	sample_exp_t pending_samples[$];
	sample_exp_t burst[$];
	sample_exp_t want;

	int  errors = 0;
	int  samples_checked = 0;
	int  bits_accepted = 0;
	int  regs_written = 0;
	int  cycle_count = 0;
	int  ready_hold = 0;
	bit  ready_steady = 1'b0;
	bit  no_gaps = 1'b0;

	// directed stimulus: typed expectations where the value is obvious
	plan_row_t plan [PLAN_LEN] = '{
		// reset values, bit zero has zero amplitude
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b1, 1'b1, 10, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b1, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b0, 1'b1, 10, 0},
		// full scale at the sine peaks, no phase advance, longest bit
		'{ROW_CFG, bkm_pkg::REG_AMP_ZERO,    16'hFFFF, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_AMP_ONE,     16'h0FFF, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_STEP_ZERO,   16'h0000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_STEP_ONE,    16'h0000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_OFFSET_ZERO, 16'h4000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_OFFSET_ONE,  16'hC000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_SPB,         16'h0040, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b0, 1'b1, 64, 4095},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b1, 1'b1, 64, -4095},
		// sample count above the cap, extreme steps and offsets
		'{ROW_CFG, bkm_pkg::REG_SPB,         16'h007F, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_STEP_ZERO,   16'hFFFF, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_STEP_ONE,    16'h0001, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_OFFSET_ZERO, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_OFFSET_ONE,  16'h8000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b0, 0, 0},
		// zero samples per bit after masking
		'{ROW_CFG, bkm_pkg::REG_SPB,         16'hFF80, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b1, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b1, 1'b1, 0, 0},
		// bit limit of two, one sample per bit
		'{ROW_CFG, bkm_pkg::REG_SPB,         16'h0001, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_BIT_LIMIT,   16'h0002, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_AMP_ZERO,    16'hF000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_AMP_ONE,     16'h0400, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_OFFSET_ONE,  16'h4000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b1, 1'b1, 1, 1024},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b1, 1, 1024},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b1, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b0, 1'b1, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b1, 1'b1, 1, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b1, 1, 1024},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b0, 1'b1, 0, 0},
		// back to unlimited, short fsk-like bits
		'{ROW_CFG, bkm_pkg::REG_BIT_LIMIT,   16'h0000, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_SPB,         16'h0005, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_STEP_ONE,    16'h3333, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_CFG, bkm_pkg::REG_OFFSET_ONE,  16'h7FFF, 1'b0, 1'b0, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b1, 1'b1, 1'b0, 0, 0},
		'{ROW_BIT, bkm_pkg::REG_AMP_ZERO, 16'h0000, 1'b0, 1'b0, 1'b0, 0, 0}
	};

	binary_keying_modulator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // data_bit, message_start
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // sample
		.m_tlast   (m_tlast),   // last_of_bit
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// one quarter of the sine wave as Q1.15, Q28 taylor series to the x^17 term
	function automatic int quarter_wave(input int unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned divisor;
		longint unsigned v;
		longint          acc;
		int              n;
		x    = (64'd421657428 * 64'(r)) >> 8;
		x2   = (x * x) >> 28;
		term = x;
		acc  = longint'(x);
		for (n = 1; n <= 8; n++) begin
			divisor = 64'(2 * n) * 64'(2 * n + 1);
			term = ((term * x2) >> 28) / divisor;
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = ($unsigned(acc) * 64'd32767 + (64'd1 << 27)) >> 28;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return int'(v);
	endfunction

	// full-cycle table built from quarter symmetry
	initial begin
		int k;
		int s;
		for (k = 0; k < 1024; k++) begin
			s = ((k >> 8) & 1) ? quarter_wave(256 - (k & 255)) : quarter_wave(k & 255);
			sine_table[k] = ((k >> 8) & 2) ? -s : s;
		end
	end

	// expected samples of one bit, left in burst
	task automatic modulate_bit(input logic data_bit, input logic msg_start);
		logic [11:0] amp;
		logic [15:0] step;
		logic [15:0] phase;
		int          count;
		int          i;
		int          s;
		int          mag;
		int          scaled;
		sample_exp_t e;
		burst.delete();
		if (msg_start) begin
			bits_sent = '0;
		end
		if (keying.bit_limit != 16'd0 && bits_sent >= keying.bit_limit) begin
			return;
		end
		if (bits_sent != 16'hFFFF) begin
			bits_sent = bits_sent + 16'd1;
		end
		count = (int'(keying.spb) > SAMPLE_CAP) ? SAMPLE_CAP : int'(keying.spb);
		amp   = data_bit ? keying.amp_one : keying.amp_zero;
		step  = data_bit ? keying.step_one : keying.step_zero;
		phase = data_bit ? keying.offset_one : keying.offset_zero;
		for (i = 0; i < count; i++) begin
			s      = sine_table[phase[15:6]];
			mag    = (s < 0) ? -s : s;
			scaled = (int'(amp) * mag + 16384) >>> 15;
			e.sample = 13'((s < 0) ? -scaled : scaled);
			e.last   = (i == count - 1);
			burst.insert(burst.size(), e);
			phase = phase + step;
		end
	endtask

	// register write on the config channel, shadow updated on acceptance
	task automatic write_reg(input bkm_pkg::reg_idx_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
			bkm_pkg::REG_AMP_ZERO:    keying.amp_zero    = data[11:0];
			bkm_pkg::REG_AMP_ONE:     keying.amp_one     = data[11:0];
			bkm_pkg::REG_STEP_ZERO:   keying.step_zero   = data;
			bkm_pkg::REG_STEP_ONE:    keying.step_one    = data;
			bkm_pkg::REG_OFFSET_ZERO: keying.offset_zero = data;
			bkm_pkg::REG_OFFSET_ONE:  keying.offset_one  = data;
			bkm_pkg::REG_SPB:         keying.spb         = data[6:0];
			bkm_pkg::REG_BIT_LIMIT:   keying.bit_limit   = data;
			default: ;
		endcase
		regs_written++;
		@(posedge clk);
	endtask

	// send one bit item; typed rows replace the predicted samples
	task automatic send_bit(input logic data_bit, input logic msg_start, input bit typed,
			input int n_typed, input int typed_val);
		int          gap;
		int          i;
		sample_exp_t e;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, msg_start, data_bit};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		bits_accepted++;
		modulate_bit(data_bit, msg_start);
		if (typed) begin
			for (i = 0; i < n_typed; i++) begin
				e.sample = 13'(typed_val);
				e.last   = (i == n_typed - 1);
				pending_samples.insert(pending_samples.size(), e);
			end
		end else begin
			for (i = 0; i < burst.size(); i++) begin
				pending_samples.insert(pending_samples.size(), burst[i]);
			end
		end
	endtask

	// hold off input until every expected sample has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// idle the block before a register write
	task automatic settle();
		drain();
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// new random register setting, upper data bits random as well
	task automatic random_setting();
		int          pick;
		logic [6:0]  spb;
		logic [15:0] limit;
		write_reg(bkm_pkg::REG_AMP_ZERO, 16'($urandom_range(0, 65535)));
		write_reg(bkm_pkg::REG_AMP_ONE, 16'($urandom_range(0, 65535)));
		pick = $urandom_range(0, 9);
		write_reg(bkm_pkg::REG_STEP_ZERO,
			(pick == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
		pick = $urandom_range(0, 9);
		write_reg(bkm_pkg::REG_STEP_ONE,
			(pick == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
		write_reg(bkm_pkg::REG_OFFSET_ZERO, 16'($urandom_range(0, 65535)));
		write_reg(bkm_pkg::REG_OFFSET_ONE, 16'($urandom_range(0, 65535)));
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			spb = 7'd0;
		end else if (pick < 12) begin
			spb = 7'($urandom_range(64, 127));
		end else begin
			spb = 7'($urandom_range(1, 12));
		end
		write_reg(bkm_pkg::REG_SPB, {9'($urandom_range(0, 511)), spb});
		pick  = $urandom_range(0, 99);
		limit = (pick < 70) ? 16'd0 : 16'($urandom_range(1, 6));
		write_reg(bkm_pkg::REG_BIT_LIMIT, limit);
	endtask

	// output side: compare each sample item and draw the next stall
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			samples_checked++;
			if (pending_samples.size() == 0) begin
				$error("unexpected sample item: sample %0d last %0b",
					$signed(m_tdata[12:0]), m_tlast);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if ($signed(m_tdata[12:0]) !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample,
						$signed(m_tdata[12:0]));
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_bit: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
			end
			if ($urandom_range(0, 39) == 0) begin
				ready_steady = !ready_steady;
			end
			ready_hold = ready_steady ? 0 : $urandom_range(0, 16);
		end
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		int row;
		int i;
		int phase_no;
		int n_bits;
		keying.amp_zero    = 12'd0;
		keying.amp_one     = 12'd2048;
		keying.step_zero   = 16'd6554;
		keying.step_one    = 16'd6554;
		keying.offset_zero = 16'd0;
		keying.offset_one  = 16'd0;
		keying.spb         = 7'd10;
		keying.bit_limit   = 16'd0;
		bits_sent          = 16'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (row = 0; row < PLAN_LEN; row++) begin
			if (plan[row].kind == ROW_CFG) begin
				settle();
				write_reg(plan[row].idx, plan[row].value);
			end else begin
				send_bit(plan[row].data_bit, plan[row].msg_start, plan[row].typed,
					plan[row].n_typed, plan[row].typed_val);
			end
		end

		// random phases, each with its own register setting
		phase_no = 0;
		while (bits_accepted < ITEM_TARGET) begin
			settle();
			random_setting();
			no_gaps = ($urandom_range(0, 3) == 0);
			n_bits  = $urandom_range(8, 20);
			for (i = 0; i < n_bits; i++) begin
				if (phase_no == 1 && i == n_bits / 2) begin
					drain();
				end
				send_bit(1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0), 1'b0, 0, 0);
			end
			phase_no++;
		end

		// wind down
		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d bit items and %0d sample items over %0d register writes",
			bits_accepted, samples_checked, regs_written);
		$display("including bit limit, zero and capped sample counts, stalls, random settings");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/bkm_pkg.sv
rtl/core/bkm_regs.sv
rtl/core/bkm_sine_rom.sv
rtl/core/bkm_gen.sv
rtl/core/bkm_scale.sv
rtl/core/binary_keying_modulator_top.sv
bench/tb_binary_keying_modulator_top.sv
